### rtl/core/b64enc_pkg.sv
package b64enc_pkg;

  // Group queue geometry.
  localparam int unsigned GQ_DEPTH = 2;
  localparam int unsigned GQ_AW    = (GQ_DEPTH > 1) ? $clog2(GQ_DEPTH) : 1;

  // Padding character.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Data characters carried by a group.
  localparam logic [2:0] NDATA_ONE_BYTE   = 3'd2;
  localparam logic [2:0] NDATA_TWO_BYTES  = 3'd3;
  localparam logic [2:0] NDATA_FULL_GROUP = 3'd4;

  // Byte-collection phases of the front end.
  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // One group of three bytes, ready for character generation.
  typedef struct packed {
    logic [23:0] bits;
    logic [2:0]  n_data;
    logic        final_grp;
  } group_t;

  // Maps a six-bit value onto the standard alphabet.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] ch;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      ch = v8 + 8'd65;
    end else if (v8 < 8'd52) begin
      ch = v8 + 8'd71;
    end else if (v8 < 8'd62) begin
      ch = v8 - 8'd4;
    end else if (v8 == 8'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

### rtl/core/base64_stream_encoder_top.sv
// Streaming base64 encoder. One raw byte is taken per transfer and can be
// taken every cycle while the group queue is not full; a third byte, or a
// byte flagged as the end of the message, closes a group that enters a
// two-group queue. The back end sends the four characters of each group,
// one per cycle unless the output is stalled, through a registered
// output, padding short final groups with '=' and flagging the final
// character. Sustained throughput is set by the one-character output
// register, which sends four characters for every three input bytes.
module base64_stream_encoder_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  b64enc_pkg::in_item_t  in_i,
  output logic                  empty,
  input  logic                  pop,
  output b64enc_pkg::out_item_t out_o
);
  import b64enc_pkg::*;

  group_t f_grp, q_grp;
  logic   f_push, q_full, q_valid, q_pop;

  b64enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .grp_push_o (f_push),
    .grp_o      (f_grp),
    .grp_full_i (q_full)
  );

  b64enc_gqueue u_gqueue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_grp),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_grp)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (q_valid),
    .grp_i       (q_grp),
    .grp_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

### rtl/core/b64enc_front.sv
module b64enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64enc_pkg::in_item_t in_i,
  output logic                grp_push_o,
  output b64enc_pkg::group_t  grp_o,
  input  logic                grp_full_i
);
  import b64enc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] b0_q, b0_d;
  logic [7:0] b1_q, b1_d;
  logic       acc;

  assign full = grp_full_i;
  assign acc  = push & ~grp_full_i;

  // Collect bytes and close a group on its third byte or on the final byte.
  always_comb begin
    phase_d    = phase_q;
    b0_d       = b0_q;
    b1_d       = b1_q;
    grp_push_o = 1'b0;
    grp_o      = '{bits: {b0_q, b1_q, in_i.data_byte}, n_data: NDATA_FULL_GROUP,
                   final_grp: in_i.end_of_message};
    case (phase_q)
      PH_ONE: begin
        if (in_i.end_of_message) begin
          grp_o.bits   = {b0_q, in_i.data_byte, 8'h00};
          grp_o.n_data = NDATA_TWO_BYTES;
          grp_push_o   = acc;
          if (acc) phase_d = PH_EMPTY;
        end else if (acc) begin
          b1_d    = in_i.data_byte;
          phase_d = PH_TWO;
        end
      end
      PH_TWO: begin
        grp_push_o = acc;
        if (acc) phase_d = PH_EMPTY;
      end
      default: begin
        if (in_i.end_of_message) begin
          grp_o.bits   = {in_i.data_byte, 16'h0000};
          grp_o.n_data = NDATA_ONE_BYTE;
          grp_push_o   = acc;
          if (acc) phase_d = PH_EMPTY;
        end else if (acc) begin
          b0_d    = in_i.data_byte;
          phase_d = PH_ONE;
        end
      end
    endcase
  end

  // Phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMPTY;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Held bytes need no reset.
  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
  end

endmodule

### rtl/core/b64enc_gqueue.sv
module b64enc_gqueue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64enc_pkg::group_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output b64enc_pkg::group_t data_o
);
  import b64enc_pkg::*;

  group_t             mem_q [GQ_DEPTH];
  logic [GQ_AW-1:0]   wr_q, rd_q;
  logic [GQ_AW:0]     cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (GQ_AW+1)'(GQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == GQ_AW'(GQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == GQ_AW'(GQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/b64enc_back.sv
module b64enc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 grp_valid_i,
  input  b64enc_pkg::group_t   grp_i,
  output logic                 grp_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output b64enc_pkg::out_item_t out_o
);
  import b64enc_pkg::*;

  group_t     cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       oval_q;
  out_item_t  out_q;
  logic       adv, done;
  logic [5:0] sextet;
  out_item_t  nxt;

  assign empty     = ~oval_q;
  assign out_o     = out_q;
  assign adv       = busy_q & (~oval_q | pop);
  assign done      = adv & (idx_q == 2'd3);
  assign grp_pop_o = grp_valid_i & (~busy_q | done);

  // Character for the current position of the group.
  always_comb begin
    case (idx_q)
      2'd0:    sextet = cur_q.bits[23:18];
      2'd1:    sextet = cur_q.bits[17:12];
      2'd2:    sextet = cur_q.bits[11:6];
      default: sextet = cur_q.bits[5:0];
    endcase
    nxt.out_char  = ({1'b0, idx_q} < cur_q.n_data) ? sextet_to_char(sextet) : PAD_CHAR;
    nxt.last_char = (idx_q == 2'd3) & cur_q.final_grp;
  end

  // Sequencer control and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
      oval_q <= 1'b0;
    end else begin
      if (adv) begin
        idx_q <= idx_q + 2'd1;
      end
      if (grp_pop_o) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        oval_q <= 1'b1;
      end else if (pop) begin
        oval_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (grp_pop_o) cur_q <= grp_i;
    if (adv) out_q <= nxt;
  end

endmodule

### tb/sv/base64_stream_encoder_checker.sv
// Watches both transfer channels of the encoder, predicts the characters
// that each accepted byte must produce, and compares every character that
// leaves the block with the oldest prediction still waiting.
module base64_stream_encoder_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  b64enc_pkg::in_item_t  in_i,
  input  logic                  empty,
  input  logic                  pop,
  input  b64enc_pkg::out_item_t out_o,
  output int unsigned           mismatches_o,
  output int unsigned           chars_due_o,
  output int unsigned           chars_checked_o
);
  import b64enc_pkg::*;

  // Standard alphabet, character 0 in the top byte.
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Predictor state: bytes held of the current group and their values.
  phase_e     bytes_held;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  // Characters predicted but not yet seen on the output.
  out_item_t  char_q[$];

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    return B64_ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches_o++;
  endtask

  // Splits one group into four sextets and queues its characters; the
  // positions past n_data become padding.
  task automatic queue_group(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [2:0] n_data,
                             input logic final_grp);
    logic [5:0] sextet [4];
    out_item_t  c;
    sextet[0] = b0[7:2];
    sextet[1] = {b0[1:0], b1[7:4]};
    sextet[2] = {b1[3:0], b2[7:6]};
    sextet[3] = b2[5:0];
    for (int k = 0; k < 4; k++) begin
      c.out_char  = (k < int'(n_data)) ? alphabet_char(sextet[k]) : PAD_CHAR;
      c.last_char = (k == 3) && final_grp;
      char_q.push_back(c);
    end
  endtask

  // Advances the predictor by one accepted byte.
  task automatic predict_byte(input in_item_t item);
    case (bytes_held)
      PH_ONE: begin
        if (item.end_of_message) begin
          queue_group(first_byte, item.data_byte, 8'h00, NDATA_TWO_BYTES, 1'b1);
          bytes_held = PH_EMPTY;
        end else begin
          second_byte = item.data_byte;
          bytes_held  = PH_TWO;
        end
      end
      PH_TWO: begin
        queue_group(first_byte, second_byte, item.data_byte, NDATA_FULL_GROUP,
                    item.end_of_message);
        bytes_held = PH_EMPTY;
      end
      default: begin
        if (item.end_of_message) begin
          queue_group(item.data_byte, 8'h00, 8'h00, NDATA_ONE_BYTE, 1'b1);
          bytes_held = PH_EMPTY;
        end else begin
          first_byte = item.data_byte;
          bytes_held = PH_ONE;
        end
      end
    endcase
  endtask

  initial begin
    mismatches_o    = 0;
    chars_due_o     = 0;
    chars_checked_o = 0;
    bytes_held      = PH_EMPTY;
  end

  // Compare outgoing characters first, then predict from the incoming byte.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t oldest;
    if (!rst_ni) begin
      bytes_held = PH_EMPTY;
      char_q.delete();
    end else begin
      if (pop && !empty) begin
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with none predicted",
                                    out_o.out_char));
        end else begin
          oldest = char_q.pop_front();
          if (out_o.out_char !== oldest.out_char) begin
            report_mismatch($sformatf("out_char 0x%02h, predicted 0x%02h",
                                      out_o.out_char, oldest.out_char));
          end
          if (out_o.last_char !== oldest.last_char) begin
            report_mismatch($sformatf("last_char %0b, predicted %0b",
                                      out_o.last_char, oldest.last_char));
          end
          chars_checked_o++;
        end
      end
      if (push && !full) begin
        predict_byte(in_i);
      end
    end
    chars_due_o = char_q.size();
  end

endmodule

### tb/sv/base64_stream_encoder_top_tb.sv
// Drives messages of raw bytes into the encoder with random gaps and
// random output stalls; the checker beside the block does the comparing.
module base64_stream_encoder_top_tb;
  import b64enc_pkg::*;

  localparam int unsigned TARGET_BYTES = 210;
  localparam int unsigned CALM_BYTES   = 175;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    in_i;
  logic        empty;
  logic        pop;
  out_item_t   out_o;

  int unsigned fail_count;
  int unsigned chars_due;
  int unsigned chars_checked;
  int unsigned bytes_sent;
  int unsigned messages_sent;
  bit          calm;
  logic [7:0]  msg_bytes[$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  base64_stream_encoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  base64_stream_encoder_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_i            (in_i),
    .empty           (empty),
    .pop             (pop),
    .out_o           (out_o),
    .mismatches_o    (fail_count),
    .chars_due_o     (chars_due),
    .chars_checked_o (chars_checked)
  );

  // Sends the bytes in msg_bytes as one message, the last one flagged.
  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          @(negedge clk_i);
          push <= 1'b0;
        end
      end
      @(negedge clk_i);
      push <= 1'b1;
      in_i <= '{data_byte: msg_bytes[i], end_of_message: (i == msg_bytes.size() - 1)};
      do @(posedge clk_i); while (full);
      bytes_sent++;
    end
    messages_sent++;
    msg_bytes.delete();
  endtask

  // Result side: stalls in bursts, none once the run has gone calm.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          @(negedge clk_i);
          pop <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk_i);
          pop <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned len;
    rst_ni        = 1'b0;
    push          = 1'b0;
    in_i          = '0;
    calm          = 1'b0;
    bytes_sent    = 0;
    messages_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed messages: lone bytes at both extremes, a two-byte tail, full
    // final groups, a lone final byte after a completed group, and bytes
    // that map onto '+' and '/'.
    msg_bytes = '{8'h00};
    send_message();
    msg_bytes = '{8'hFF};
    send_message();
    msg_bytes = '{8'h00, 8'hFF};
    send_message();
    msg_bytes = '{8'hFF, 8'hFF, 8'hFF};
    send_message();
    msg_bytes = '{8'h4D, 8'h61, 8'h6E};
    send_message();
    msg_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF};
    send_message();
    msg_bytes = '{8'hFB, 8'hEF, 8'hBE, 8'h12, 8'h34};
    send_message();
    msg_bytes = '{8'h14, 8'hFB, 8'h9C, 8'h03, 8'hD9, 8'h7E};
    send_message();

    // Hold off the sender until every predicted character has come out.
    @(negedge clk_i);
    push <= 1'b0;
    while (chars_due != 0) @(negedge clk_i);

    // Random messages, mostly short, now and then a long one.
    while (bytes_sent < TARGET_BYTES) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
      repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
      if (bytes_sent >= CALM_BYTES) calm = 1'b1;
      send_message();
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (chars_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d bytes in %0d messages, %0d characters checked",
             bytes_sent, messages_sent, chars_checked);
    $display("all group endings, stalls on both sides and a fully drained pause");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
